FILE: hdl/hbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg
// shared types, codes and helpers for the http body deframer
// ----------------------------------------------------------------------------
package hbd_pkg;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERRUN  = 2'd1,
        ERR_SIZE_OVF = 2'd2,
        ERR_BAD_HEX  = 2'd3
    } t_err;

    localparam logic MODE_LENGTH  = 1'b0;
    localparam logic MODE_CHUNKED = 1'b1;

    localparam logic REG_FRAMING = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam int CRLF_LEN = 2;

    typedef struct packed {
        logic       framing_mode;
        logic [31:0] body_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       read_end;
    } t_item;

    typedef struct packed {
        logic [7:0] entity_byte;
        logic       entity_valid;
        logic       body_done;
        t_err       error_code;
        logic       read_end_out;
    } t_res;

    // returns {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

FILE: hdl/hbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_in_if
// body byte request channel
// ----------------------------------------------------------------------------
interface hbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       read_end;

    modport source (output valid, data_byte, first_byte, read_end, input ready);
    modport sink   (input valid, data_byte, first_byte, read_end, output ready);
endinterface

FILE: hdl/hbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_out_if
// decoded entity result channel
// ----------------------------------------------------------------------------
interface hbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] entity_byte;
    logic       entity_valid;
    logic       body_done;
    logic [1:0] error_code;
    logic       read_end_out;

    modport source (output valid, entity_byte, entity_valid, body_done, error_code,
                    read_end_out, input ready);
    modport sink   (input valid, entity_byte, entity_valid, body_done, error_code,
                    read_end_out, output ready);
endinterface

FILE: hdl/http_body_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_body_deframer
// recovers entity bytes from a content-length or chunked http body
// ----------------------------------------------------------------------------
//  port      dir  handshake         payload
//  i_req     in   valid/ready       data_byte, first_byte, read_end
//  o_res     out  valid/ready       entity_byte, entity_valid, body_done,
//                                   error_code, read_end_out
//  apb       in   psel/penable      framing mode at 0x0, content length at 0x4
//
//  one byte per cycle sustained while o_res is not stalled; a taken request
//  is registered in the input register, then in the result register on o_res
//  the running state updates as a byte moves from input to result register
//  a stalled o_res holds its result; the input register takes one more
//  request, then i_req.ready drops until o_res is taken
//  synchronous active-low reset clears state and configuration
// ----------------------------------------------------------------------------
module http_body_deframer
    import hbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbd_in_if.sink      i_req,
    hbd_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  w_cfg;
    t_item r_s1;
    logic  r_s1_valid;
    t_res  r_s2;
    logic  r_s2_valid;
    t_res  w_res;
    logic  w_s2_free;
    logic  w_adv;

    hbd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hbd_decode #(
        .SIZE_BITS (SIZE_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_s1),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_s2_free   = !r_s2_valid || o_res.ready;
    assign w_adv       = r_s1_valid && w_s2_free;
    assign i_req.ready = !r_s1_valid || w_s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1.data_byte  <= i_req.data_byte;
            r_s1.first_byte <= i_req.first_byte;
            r_s1.read_end   <= i_req.read_end;
        end
        if (w_adv) begin
            r_s2 <= w_res;
        end
    end

    assign o_res.valid        = r_s2_valid;
    assign o_res.entity_byte  = r_s2.entity_byte;
    assign o_res.entity_valid = r_s2.entity_valid;
    assign o_res.body_done    = r_s2.body_done;
    assign o_res.error_code   = r_s2.error_code;
    assign o_res.read_end_out = r_s2.read_end_out;

endmodule

FILE: hdl/hbd_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_apb_regs
// apb configuration registers: framing mode and content length
// ----------------------------------------------------------------------------
module hbd_apb_regs
    import hbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic        r_mode;
    logic [31:0] r_length;
    logic        w_wr;
    logic        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LENGTH;
            r_length <= 32'd0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FRAMING: r_mode   <= pwdata[0];
                REG_LENGTH:  r_length <= pwdata;
                default:     r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FRAMING: prdata = {31'd0, r_mode};
            REG_LENGTH:  prdata = r_length;
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.framing_mode = r_mode;
    assign o_cfg.body_len     = r_length;

endmodule

FILE: hdl/hbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_decode
// running body state and the per-byte framing decision
// ----------------------------------------------------------------------------
module hbd_decode
    import hbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase, w_phase;
    logic [SIZE_BITS-1:0]  r_hex, n_hex, w_hex;
    logic [SIZE_BITS:0]    r_rem, n_rem, w_rem;
    logic [31:0]           r_cnt, n_cnt, w_cnt;
    t_err                  r_err, n_err, w_err;
    logic                  w_valid;
    logic                  w_done;
    logic [4:0]            w_digit;

    // first byte of a body starts from clean state
    always_comb begin
        if (i_item.first_byte) begin
            w_phase = PH_SIZE;
            w_hex   = '0;
            w_rem   = '0;
            w_cnt   = 32'd0;
            w_err   = ERR_NONE;
        end else begin
            w_phase = r_phase;
            w_hex   = r_hex;
            w_rem   = r_rem;
            w_cnt   = r_cnt;
            w_err   = r_err;
        end
    end

    assign w_digit = hex_digit(i_item.data_byte);

    always_comb begin
        n_phase = w_phase;
        n_hex   = w_hex;
        n_rem   = w_rem;
        n_cnt   = w_cnt;
        n_err   = w_err;
        w_valid = 1'b0;
        w_done  = 1'b0;
        if (w_err == ERR_NONE) begin
            if (i_cfg.framing_mode == MODE_LENGTH) begin
                if (w_cnt < i_cfg.body_len) begin
                    n_cnt   = w_cnt + 32'd1;
                    w_valid = 1'b1;
                    w_done  = (n_cnt == i_cfg.body_len);
                end else begin
                    n_err = ERR_OVERRUN;
                end
            end else begin
                unique case (w_phase)
                    PH_DONE: w_done = 1'b1;
                    PH_DATA: begin
                        w_valid = (w_rem > (SIZE_BITS+1)'(CRLF_LEN));
                        if (w_rem != '0) begin
                            n_rem = w_rem - (SIZE_BITS+1)'(1);
                        end
                        if (n_rem == '0) begin
                            n_phase = PH_SIZE;
                        end
                    end
                    default: begin
                        if (i_item.data_byte == CH_LF) begin
                            if (w_hex == '0) begin
                                n_phase = PH_DONE;
                                w_done  = 1'b1;
                            end else begin
                                n_rem   = {1'b0, w_hex} + (SIZE_BITS+1)'(CRLF_LEN);
                                n_hex   = '0;
                                n_phase = PH_DATA;
                            end
                        end else if (i_item.data_byte != CH_CR) begin
                            if (!w_digit[4]) begin
                                n_err = ERR_BAD_HEX;
                            end else if (w_hex[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_err = ERR_SIZE_OVF;
                            end else begin
                                n_hex = {w_hex[SIZE_BITS-5:0], w_digit[3:0]};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_hex   <= '0;
            r_rem   <= '0;
            r_cnt   <= 32'd0;
            r_err   <= ERR_NONE;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    assign o_res.entity_byte  = w_valid ? i_item.data_byte : 8'd0;
    assign o_res.entity_valid = w_valid;
    assign o_res.body_done    = (n_err == ERR_NONE) && w_done;
    assign o_res.error_code   = n_err;
    assign o_res.read_end_out = i_item.read_end;

endmodule
